>>> rtl/ndd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndd_pkg
// Shared types, constants and helpers for the divided-difference interpolator.
// ----------------------------------------------------------------------------
package ndd_pkg;

    // Q24.24 saturation limit
    localparam logic signed [47:0] LIM48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [48:0] LIM49 = 49'sh0_7FFF_FFFF_FFFF;

    // Range status codes
    localparam logic [1:0] RS_INSIDE = 2'd0;
    localparam logic [1:0] RS_BELOW  = 2'd1;
    localparam logic [1:0] RS_ABOVE  = 2'd2;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL16,
        ALU_MUL24,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [47:0] result;
    } t_alu_rsp;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DD_RD,
        ST_DD_CALC,
        ST_DD_DIV,
        ST_DD_STORE,
        ST_EV_CHK0,
        ST_EV_CHK1,
        ST_EV_CHK2,
        ST_EV_INIT,
        ST_EV_RD,
        ST_EV_MUL1,
        ST_EV_MUL1W,
        ST_EV_MUL2W,
        ST_EV_CONV,
        ST_FINISH
    } t_state;

    // Clamp a 49-bit sum to +-(2^47 - 1)
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > LIM49) begin
            r = LIM48;
        end else if (v < -LIM49) begin
            r = -LIM48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // Q24.24 to Q16.16, truncate toward zero, saturate to 32 bits
    function automatic logic signed [31:0] to_q16(input logic signed [47:0] acc);
        logic [47:0]        mag;
        logic [39:0]        m;
        logic signed [31:0] r;
        mag = acc[47] ? 48'(-acc) : 48'(acc);
        m   = mag[47:8];
        if (acc[47]) begin
            if (m > 40'h00_8000_0000) begin
                r = 32'sh8000_0000;
            end else begin
                r = -$signed(m[31:0]);
            end
        end else begin
            if (m > 40'h00_7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end else begin
                r = $signed(m[31:0]);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/ndd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndd_in_if
// Sample channel: one sample pair per transfer, last one carries the query.
// ----------------------------------------------------------------------------
interface ndd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] query_x;
    logic               last_sample;

    modport source (output valid, sample_x, sample_y, query_x, last_sample,
                    input ready);
    modport sink   (input valid, sample_x, sample_y, query_x, last_sample,
                    output ready);
endinterface

>>> rtl/ndd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndd_out_if
// Result channel: interpolated value with range and error flags.
// ----------------------------------------------------------------------------
interface ndd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         range_status;
    logic               divide_error;

    modport source (output valid, value, range_status, divide_error, input ready);
    modport sink   (input valid, value, range_status, divide_error, output ready);
endinterface

>>> rtl/ndd_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndd_alu
// Shared iterative unit: shift-add multiply (48 steps) with a fixed right
// shift, or restoring divide of |a|*2^16 by |b| (64 steps). Sign-magnitude,
// truncation toward zero, saturation to +-(2^47 - 1).
// ----------------------------------------------------------------------------
module ndd_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ndd_pkg::t_alu_req i_req,
    output ndd_pkg::t_alu_rsp o_rsp
);
    import ndd_pkg::*;

    localparam logic [6:0] MulSteps = 7'd48;
    localparam logic [6:0] DivSteps = 7'd64;

    logic               r_busy;
    logic               r_done;
    t_alu_op            r_op;
    logic               r_neg;
    logic [6:0]         r_cnt;
    logic [47:0]        r_mcand;
    logic [47:0]        r_hi;
    logic [47:0]        r_lo;
    logic [32:0]        r_rem;
    logic [63:0]        r_quo;
    logic signed [47:0] r_res;

    logic [47:0] a_mag;
    logic [47:0] b_mag;
    logic [48:0] mul_sum;
    logic [33:0] rem_sh;
    logic        rem_ge;
    logic [95:0] prod;
    logic        sat;
    logic [46:0] res_mag;

    assign a_mag = i_req.a[47] ? 48'(-i_req.a) : 48'(i_req.a);
    assign b_mag = i_req.b[47] ? 48'(-i_req.b) : 48'(i_req.b);

    // one multiply or divide step
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 49'd0);
    assign rem_sh  = {r_rem, r_quo[63]};
    assign rem_ge  = rem_sh >= {1'b0, r_mcand[32:0]};

    // final scaling and saturation
    assign prod = {r_hi, r_lo};
    always_comb begin
        case (r_op)
            ALU_MUL16: begin
                sat     = |prod[95:63];
                res_mag = prod[62:16];
            end
            ALU_MUL24: begin
                sat     = |prod[95:71];
                res_mag = prod[70:24];
            end
            ALU_DIV: begin
                sat     = |r_quo[63:47];
                res_mag = r_quo[46:0];
            end
            default: begin
                sat     = 1'b0;
                res_mag = '0;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == ALU_DIV) ? DivSteps : MulSteps;
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_neg <= i_req.a[47] ^ i_req.b[47];
            r_hi  <= '0;
            r_rem <= '0;
            if (i_req.op == ALU_DIV) begin
                r_mcand <= {15'd0, b_mag[32:0]};
                r_quo   <= {a_mag, 16'd0};
                r_lo    <= '0;
            end else begin
                r_mcand <= a_mag;
                r_lo    <= b_mag;
                r_quo   <= '0;
            end
        end else if (r_busy && r_cnt != 7'd0) begin
            if (r_op == ALU_DIV) begin
                r_rem <= rem_ge ? 33'(rem_sh - {1'b0, r_mcand[32:0]}) : rem_sh[32:0];
                r_quo <= {r_quo[62:0], rem_ge};
            end else begin
                r_hi <= mul_sum[48:1];
                r_lo <= {mul_sum[0], r_lo[47:1]};
            end
        end else if (r_busy) begin
            r_res <= r_neg ? -$signed({1'b0, (sat ? LIM48[46:0] : res_mag)})
                           :  $signed({1'b0, (sat ? LIM48[46:0] : res_mag)});
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    // assertions
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("start while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy) else $error("done without run");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DivSteps) else $error("step count out of range");

endmodule

>>> rtl/newton_divided_difference_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_divided_difference_interp
// Newton divided-difference interpolator over up to MAX_POINTS samples.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one sample (x ascending, y) per transfer, Q16.16. The transfer
//           with last_sample set also carries query_x and triggers a result.
//           Samples beyond MAX_POINTS in one set are dropped.
//   o_out : one result per set: value (Q16.16, saturated), range_status
//           (inside / clamped below / clamped above), divide_error.
// Shared-unit work:
//   sample transfer : one 64-step serial divide on the shared unit per
//                     table row entry with a nonzero x difference.
//   evaluation      : two 48-step multiplies on the same unit per
//                     coefficient above the first.
//   Ready is low while a sample or an evaluation is being worked.
// Reset clears the set and any pending result. A finished result sits in an
// output register; the next set is accepted meanwhile, and only a second
// result waits for the receiver to take the first.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp #(
    parameter int MAX_POINTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ndd_in_if.sink       i_in,
    ndd_out_if.source    o_out
);
    import ndd_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);
    localparam logic [CW-1:0] One    = CW'(1);

    t_state r_state, n_state;

    logic signed [31:0] r_x, r_y, r_q;
    logic               r_last;
    logic signed [47:0] r_t, r_term, r_acc, r_coef;
    logic [CW-1:0]      r_j, r_k, r_count;
    logic               r_err;
    logic signed [31:0] r_first_y, r_last_y;
    logic signed [31:0] r_res_value;
    logic [1:0]         r_res_status;
    logic               r_res_err;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [1:0]         r_out_status;
    logic               r_out_err;

    // stores
    logic signed [31:0] abs_mem  [MAX_POINTS];
    logic signed [47:0] row_mem  [MAX_POINTS];
    logic signed [47:0] coef_mem [MAX_POINTS];
    logic signed [31:0] r_abs_rd;
    logic signed [47:0] r_row_rd, r_coef_rd;

    logic [AW-1:0]      abs_raddr, row_raddr, coef_raddr, row_waddr;
    logic               row_we;
    logic signed [47:0] row_wdata;

    logic               in_xfer, out_free;
    logic signed [32:0] den, qdiff;
    logic signed [47:0] dd_num;
    logic [CW-1:0]      n_minus_j, j_minus_1, k_minus_1;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    ndd_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign den       = {r_x[31], r_x} - {r_abs_rd[31], r_abs_rd};
    assign qdiff     = {r_q[31], r_q} - {r_abs_rd[31], r_abs_rd};
    assign dd_num    = sat48({r_t[47], r_t} - {r_row_rd[47], r_row_rd});
    assign n_minus_j = r_count - r_j;
    assign j_minus_1 = r_j - One;
    assign k_minus_1 = r_k - One;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (r_count < MaxCnt) begin
                        n_state = (r_count == '0) ? ST_DD_STORE : ST_DD_RD;
                    end else begin
                        n_state = i_in.last_sample ? ST_EV_CHK0 : ST_IDLE;
                    end
                end
            end
            ST_DD_RD:   n_state = ST_DD_CALC;
            ST_DD_CALC: begin
                if (den == '0) begin
                    n_state = (r_j == r_count) ? ST_DD_STORE : ST_DD_RD;
                end else begin
                    n_state = ST_DD_DIV;
                end
            end
            ST_DD_DIV: begin
                if (alu_rsp.done) begin
                    n_state = (r_j == r_count) ? ST_DD_STORE : ST_DD_RD;
                end
            end
            ST_DD_STORE: n_state = r_last ? ST_EV_CHK0 : ST_IDLE;
            ST_EV_CHK0:  n_state = r_err ? ST_FINISH : ST_EV_CHK1;
            ST_EV_CHK1:  n_state = (r_q < r_abs_rd) ? ST_FINISH : ST_EV_CHK2;
            ST_EV_CHK2:  n_state = (r_q > r_abs_rd) ? ST_FINISH : ST_EV_INIT;
            ST_EV_INIT:  n_state = (r_count == One) ? ST_EV_CONV : ST_EV_RD;
            ST_EV_RD:    n_state = ST_EV_MUL1;
            ST_EV_MUL1:  n_state = ST_EV_MUL1W;
            ST_EV_MUL1W: n_state = alu_rsp.done ? ST_EV_MUL2W : ST_EV_MUL1W;
            ST_EV_MUL2W: begin
                if (alu_rsp.done) begin
                    n_state = (r_k + One == r_count) ? ST_EV_CONV : ST_EV_RD;
                end
            end
            ST_EV_CONV: n_state = ST_FINISH;
            ST_FINISH:  n_state = out_free ? ST_IDLE : ST_FINISH;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control outputs: ready, store addresses, shared unit requests
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        abs_raddr  = '0;
        row_raddr  = j_minus_1[AW-1:0];
        coef_raddr = '0;
        row_we     = 1'b0;
        row_waddr  = j_minus_1[AW-1:0];
        row_wdata  = r_t;
        alu_req    = '{start: 1'b0, op: ALU_DIV, a: dd_num, b: 48'(den)};
        case (r_state)
            ST_DD_RD: begin
                abs_raddr = n_minus_j[AW-1:0];
            end
            ST_DD_CALC: begin
                row_we        = 1'b1;
                alu_req.start = (den != '0);
            end
            ST_DD_STORE: begin
                row_we    = 1'b1;
                row_waddr = r_count[AW-1:0];
            end
            ST_EV_CHK1: begin
                abs_raddr = AW'(r_count - One);
            end
            ST_EV_CHK2: begin
                coef_raddr = '0;
            end
            ST_EV_RD: begin
                abs_raddr  = k_minus_1[AW-1:0];
                coef_raddr = r_k[AW-1:0];
            end
            ST_EV_MUL1: begin
                alu_req = '{start: 1'b1, op: ALU_MUL16, a: r_term, b: 48'(qdiff)};
            end
            ST_EV_MUL1W: begin
                alu_req = '{start: alu_rsp.done, op: ALU_MUL24, a: r_coef,
                            b: alu_rsp.result};
            end
            default: begin
            end
        endcase
    end

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_xfer && r_count < MaxCnt) begin
            abs_mem[r_count[AW-1:0]] <= i_in.sample_x;
        end
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (r_state == ST_DD_STORE) begin
            coef_mem[r_count[AW-1:0]] <= r_t;
        end
        r_abs_rd  <= abs_mem[abs_raddr];
        r_row_rd  <= row_mem[row_raddr];
        r_coef_rd <= coef_mem[coef_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_first_y   <= '0;
            r_last_y    <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_DD_CALC: begin
                    if (den == '0) begin
                        r_err <= 1'b1;
                    end
                end
                ST_DD_STORE: begin
                    if (r_count == '0) begin
                        r_first_y <= r_y;
                    end
                    r_last_y <= r_y;
                    r_count  <= r_count + One;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_err       <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_x    <= i_in.sample_x;
                    r_y    <= i_in.sample_y;
                    r_q    <= i_in.query_x;
                    r_last <= i_in.last_sample;
                    r_t    <= 48'(i_in.sample_y) <<< 8;
                    r_j    <= One;
                end
            end
            ST_DD_CALC: begin
                if (den == '0) begin
                    r_t <= '0;
                    r_j <= r_j + One;
                end
            end
            ST_DD_DIV: begin
                if (alu_rsp.done) begin
                    r_t <= alu_rsp.result;
                    r_j <= r_j + One;
                end
            end
            ST_EV_CHK0: begin
                r_res_value  <= '0;
                r_res_status <= RS_INSIDE;
                r_res_err    <= 1'b1;
            end
            ST_EV_CHK1: begin
                r_res_value  <= r_first_y;
                r_res_status <= RS_BELOW;
                r_res_err    <= 1'b0;
            end
            ST_EV_CHK2: begin
                r_res_value  <= r_last_y;
                r_res_status <= RS_ABOVE;
            end
            ST_EV_INIT: begin
                r_acc  <= r_coef_rd;
                r_term <= 48'sd1 <<< 24;
                r_k    <= One;
            end
            ST_EV_MUL1: begin
                r_coef <= r_coef_rd;
            end
            ST_EV_MUL1W: begin
                if (alu_rsp.done) begin
                    r_term <= alu_rsp.result;
                end
            end
            ST_EV_MUL2W: begin
                if (alu_rsp.done) begin
                    r_acc <= sat48({r_acc[47], r_acc} + {alu_rsp.result[47], alu_rsp.result});
                    r_k   <= r_k + One;
                end
            end
            ST_EV_CONV: begin
                r_res_value  <= to_q16(r_acc);
                r_res_status <= RS_INSIDE;
                r_res_err    <= 1'b0;
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out_value  <= r_res_value;
                    r_out_status <= r_res_status;
                    r_out_err    <= r_res_err;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.range_status = r_out_status;
    assign o_out.divide_error = r_out_err;

    // assertions
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCnt) else $error("sample count overflow");
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && out_free) |=> r_out_valid && r_count == '0)
        else $error("result not loaded");
    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == ST_DD_DIV || r_state == ST_EV_MUL1W ||
                          r_state == ST_EV_MUL2W)) else $error("stray unit result");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.busy |-> !i_in.ready) else $error("ready during computation");

endmodule
